// File: hw/rtl/spim_pkg.sv
// spim_pkg: shared types and constants of the buffered SPI master.
// Used by spim_core, spim_out_buf and spi_master_buffered_shift; no dependencies.
package spim_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int INDEX_WIDTH  = 5;
   localparam int LENGTH_WIDTH = 9;
   localparam int CSR_WIDTH    = 14;
   localparam int ADDR_WORDS   = 16;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   localparam logic [INDEX_WIDTH-1:0] REG_LENGTH = 5'd16;
   localparam logic [INDEX_WIDTH-1:0] REG_START  = 5'd17;

   localparam logic CSR_PRESCALE = 1'b0;
   localparam logic CSR_MODE     = 1'b1;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_value;
      logic                  sclk_level;
      logic                  mosi_level;
      logic                  busy_res;
   } rsp_type;

endpackage

// File: hw/rtl/spim_out_buf.sv
// spim_out_buf: two-entry response queue that decouples the core from the
// response channel. Depends on spim_pkg for the response type.
module spim_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  spim_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output spim_pkg::rsp_type out_data
);

   logic              v0_ff, v0_in;
   logic              v1_ff, v1_in;
   spim_pkg::rsp_type slot0_ff, slot0_in;
   spim_pkg::rsp_type slot1_ff, slot1_in;
   logic              push;
   logic              pop;

   assign in_ready  = !v1_ff;
   assign out_valid = v0_ff;
   assign out_data  = slot0_ff;
   assign push      = in_valid && !v1_ff;
   assign pop       = v0_ff && out_ready;

   always_comb begin
      v0_in    = v0_ff;
      v1_in    = v1_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (!v0_ff) begin
         if (push) begin
            slot0_in = in_data;
            v0_in    = 1'b1;
         end
      end else if (!v1_ff) begin
         if (pop && push) begin
            slot0_in = in_data;
         end else if (pop) begin
            v0_in = 1'b0;
         end else if (push) begin
            slot1_in = in_data;
            v1_in    = 1'b1;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         v1_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// File: hw/rtl/spim_core.sv
// spim_core: request decode, transfer sequencer, word buffer memory and the
// request result stage. Depends on spim_pkg.
module spim_core #(
   parameter int BUFFER_WORDS = 16,
   parameter int PRESCALE_MAX = 8192
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [spim_pkg::INDEX_WIDTH-1:0]    req_reg_index,
   input  logic [spim_pkg::DATA_WIDTH-1:0]     req_write_value,
   input  logic                                req_miso_bit,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [spim_pkg::CSR_WIDTH-1:0]      csr_wdata,
   output logic                                out_valid,
   input  logic                                out_ready,
   output spim_pkg::rsp_type                   out_data
);

   localparam int AW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
   localparam int TW = $clog2(PRESCALE_MAX);
   localparam int HW = $clog2(PRESCALE_MAX + 1);
   localparam int LW = spim_pkg::LENGTH_WIDTH;
   localparam int DW = spim_pkg::DATA_WIDTH;

   logic [DW-1:0] data_mem [BUFFER_WORDS];

   logic [LW-1:0] length_ff, length_in;
   logic [LW-1:0] bitpos_ff, bitpos_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [HW-1:0] half_ff, half_in;
   logic [1:0]    mode_ff, mode_in;
   logic          phase_ff, phase_in;
   logic          active_ff, active_in;
   logic          sclk_ff, sclk_in;
   logic          mosi_ff, mosi_in;
   logic [DW-1:0] word0_ff, word0_in;
   logic [DW-1:0] work_ff, work_in;
   logic [DW-1:0] next_ff;
   logic [DW-1:0] rdata_ff;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_sel_mem_ff;
   spim_pkg::rsp_type s1_res_ff, s1_res_in;

   logic          accept;
   logic          cpol, cpha;
   logic [3:0]    wcur;
   logic [4:0]    nidx;
   logic          cur_is0, cur_ok, new_ok;
   logic [4:0]    bsel, nsel;
   logic [LW-1:0] newpos;
   logic          last_tick;
   logic          idx_word;
   logic          put_now;
   logic [DW-1:0] cw;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;
   logic          rd_en;
   logic          sel_mem;
   logic [DW-1:0] rd_dir;

   assign req_ready = !s1_valid_ff || out_ready;
   assign accept    = req_valid && req_ready;
   assign out_valid = s1_valid_ff;

   assign cpol      = mode_ff[1];
   assign cpha      = mode_ff[0];
   assign wcur      = bitpos_ff[8:5];
   assign nidx      = {1'b0, wcur} + 5'd1;
   assign cur_is0   = (wcur == 4'd0);
   assign cur_ok    = 32'(wcur) < BUFFER_WORDS;
   assign bsel      = {bitpos_ff[4:3], ~bitpos_ff[2:0]};
   assign newpos    = bitpos_ff + LW'(1);
   assign nsel      = {newpos[4:3], ~newpos[2:0]};
   assign new_ok    = 32'(newpos[8:5]) < BUFFER_WORDS;
   assign last_tick = (HW'(tick_ff) + HW'(1)) >= half_ff;
   assign idx_word  = (32'(req_reg_index) < spim_pkg::ADDR_WORDS)
                      && (32'(req_reg_index) < BUFFER_WORDS);
   assign put_now   = accept && (req_cmd == spim_pkg::CMD_TICK) && active_ff
                      && last_tick && cur_ok && (phase_ff ? cpha : !cpha);

   always_comb begin
      length_in = length_ff;
      bitpos_in = bitpos_ff;
      tick_in   = tick_ff;
      half_in   = half_ff;
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      active_in = active_ff;
      sclk_in   = sclk_ff;
      mosi_in   = mosi_ff;
      word0_in  = word0_ff;
      work_in   = work_ff;
      mem_we    = 1'b0;
      mem_waddr = AW'(wcur);
      rd_en     = 1'b0;
      sel_mem   = 1'b0;
      rd_dir    = '0;

      cw = cur_is0 ? word0_ff : work_ff;
      if (put_now) begin
         cw[bsel] = req_miso_bit;
         if (cur_is0) begin
            word0_in = cw;
         end else begin
            work_in = cw;
         end
      end
      mem_wdata = cw;

      if (csr_we && !active_ff) begin
         case (csr_index)
            spim_pkg::CSR_PRESCALE: begin
               if (csr_wdata == '0) begin
                  half_in = HW'(1);
               end else if (32'(csr_wdata) > PRESCALE_MAX) begin
                  half_in = HW'(PRESCALE_MAX);
               end else begin
                  half_in = HW'(csr_wdata);
               end
            end
            spim_pkg::CSR_MODE: begin
               mode_in = csr_wdata[1:0];
               sclk_in = csr_wdata[1];
            end
            default: ;
         endcase
      end

      if (accept) begin
         case (req_cmd)
            spim_pkg::CMD_WRITE: begin
               if (!active_ff) begin
                  if (idx_word) begin
                     if (req_reg_index == '0) begin
                        word0_in = req_write_value;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(req_reg_index);
                        mem_wdata = req_write_value;
                     end
                  end else if (req_reg_index == spim_pkg::REG_LENGTH) begin
                     length_in = req_write_value[LW-1:0];
                  end else if (req_reg_index == spim_pkg::REG_START
                               && req_write_value[0]) begin
                     active_in = 1'b1;
                     bitpos_in = '0;
                     tick_in   = '0;
                     phase_in  = 1'b0;
                     sclk_in   = cpol;
                     if (!cpha) begin
                        mosi_in = word0_ff[7];
                     end
                  end
               end
            end
            spim_pkg::CMD_READ: begin
               if (idx_word) begin
                  if (req_reg_index == '0) begin
                     rd_dir = word0_ff;
                  end else if (active_ff && req_reg_index[3:0] == wcur) begin
                     rd_dir = work_ff;
                  end else begin
                     sel_mem = 1'b1;
                     rd_en   = 1'b1;
                  end
               end else if (req_reg_index == spim_pkg::REG_LENGTH) begin
                  rd_dir = DW'(length_ff);
               end else if (req_reg_index == spim_pkg::REG_START) begin
                  rd_dir = DW'(active_ff);
               end
            end
            spim_pkg::CMD_TICK: begin
               if (active_ff) begin
                  if (!last_tick) begin
                     tick_in = tick_ff + TW'(1);
                  end else begin
                     tick_in = '0;
                     if (!phase_ff) begin
                        // leading edge
                        sclk_in  = ~cpol;
                        phase_in = 1'b1;
                        if (cpha) begin
                           mosi_in = cur_ok && cw[bsel];
                        end
                     end else begin
                        // trailing edge
                        sclk_in  = cpol;
                        phase_in = 1'b0;
                        if (bitpos_ff >= length_ff) begin
                           active_in = 1'b0;
                           bitpos_in = '0;
                           if (!cur_is0 && cur_ok) begin
                              mem_we = 1'b1;
                           end
                        end else begin
                           bitpos_in = newpos;
                           if (newpos[4:0] == 5'd0) begin
                              if (!cur_is0 && cur_ok) begin
                                 mem_we = 1'b1;
                              end
                              work_in = next_ff;
                              if (!cpha) begin
                                 mosi_in = new_ok && next_ff[nsel];
                              end
                           end else if (!cpha) begin
                              mosi_in = cur_ok && cw[nsel];
                           end
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      s1_res_in.read_value = rd_dir;
      s1_res_in.sclk_level = sclk_in;
      s1_res_in.mosi_level = mosi_in;
      s1_res_in.busy_res   = active_in;
      s1_valid_in          = accept || (s1_valid_ff && !out_ready);
   end

   always_comb begin
      out_data = s1_res_ff;
      if (s1_sel_mem_ff) begin
         out_data.read_value = rdata_ff;
      end
   end

   // word buffer: one write port, bus read port and prefetch read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         data_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rdata_ff <= data_mem[AW'(req_reg_index)];
      end
      next_ff <= data_mem[AW'(nidx)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         bitpos_ff   <= '0;
         tick_ff     <= '0;
         half_ff     <= HW'(1);
         mode_ff     <= '0;
         phase_ff    <= 1'b0;
         active_ff   <= 1'b0;
         sclk_ff     <= 1'b0;
         mosi_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         length_ff   <= length_in;
         bitpos_ff   <= bitpos_in;
         tick_ff     <= tick_in;
         half_ff     <= half_in;
         mode_ff     <= mode_in;
         phase_ff    <= phase_in;
         active_ff   <= active_in;
         sclk_ff     <= sclk_in;
         mosi_ff     <= mosi_in;
         s1_valid_ff <= s1_valid_in;
      end
      word0_ff <= word0_in;
      work_ff  <= work_in;
      if (accept) begin
         s1_res_ff     <= s1_res_in;
         s1_sel_mem_ff <= sel_mem;
      end
   end

endmodule

// File: hw/rtl/spi_master_buffered_shift.sv
// Buffered SPI master, modes 0 to 3, one response per request.
// Each response is registered in the result stage, then in the response queue.
// Throughput: one request per cycle unless the result stage waits on a full
// two-entry response queue; both let requests flow while responses wait.
// Reset: synchronous, active high; control state clears, buffer words stay
// undefined until written.
module spi_master_buffered_shift #(
   parameter int BUFFER_WORDS = 16,
   parameter int PRESCALE_MAX = 8192
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_cmd,
   input  logic [spim_pkg::INDEX_WIDTH-1:0] req_reg_index,
   input  logic [spim_pkg::DATA_WIDTH-1:0]  req_write_value,
   input  logic                             req_miso_bit,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [spim_pkg::DATA_WIDTH-1:0]  rsp_read_value,
   output logic                             rsp_sclk_level,
   output logic                             rsp_mosi_level,
   output logic                             rsp_busy_res,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [spim_pkg::CSR_WIDTH-1:0]   csr_wdata
);

   logic              core_valid;
   logic              buf_ready;
   spim_pkg::rsp_type core_data;
   spim_pkg::rsp_type rsp_data;

   spim_core #(
      .BUFFER_WORDS (BUFFER_WORDS),
      .PRESCALE_MAX (PRESCALE_MAX)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_reg_index   (req_reg_index),
      .req_write_value (req_write_value),
      .req_miso_bit    (req_miso_bit),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .out_valid       (core_valid),
      .out_ready       (buf_ready),
      .out_data        (core_data)
   );

   spim_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (core_valid),
      .in_ready  (buf_ready),
      .in_data   (core_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_read_value = rsp_data.read_value;
   assign rsp_sclk_level = rsp_data.sclk_level;
   assign rsp_mosi_level = rsp_data.mosi_level;
   assign rsp_busy_res   = rsp_data.busy_res;

endmodule
